// ----- sv/bilin_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the bilinear grid interpolator.
// No dependencies; imported by the top level.
package bilin_pkg;

    // Command codes carried in tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_INTERP = 1'b1;

    // Field widths of the stream items
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 16;
    localparam int COORD_W  = 18;
    localparam int RESULT_W = 16;

    // Input tdata layout, last field in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] y_norm;
        logic signed [COORD_W-1:0] x_norm;
        logic signed [VALUE_W-1:0] entry_value;
        logic        [INDEX_W-1:0] entry_index;
    } in_item_t;

endpackage

// ----- sv/bilin_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on an address collision. No dependencies.
module bilin_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage and registered read; a read in the write cycle returns old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/bilinear_interp_4x4_grid.sv -----
`timescale 1ns / 1ps
// Bilinear interpolator over a square table of signed Q7.8 values.
// Depends on bilin_pkg and bilin_ram.
//
// Usage:
//   Input stream (s_*): tuser is the command. A write transfer stores
//   entry_value at entry_index (row*GRID_SIDE+col) and gives no result.
//   An interpolate transfer brings x_norm (row) and y_norm (column) and
//   gives exactly one result transfer on the output stream (m_*).
//   Results leave in the order their items arrived.
// Throughput: one item per cycle unless m_tready stalls. The six-stage
//   pipeline (clamp, table read, two multiply stages with an add stage
//   between them, final sum and rounding) moves on a per-stage enable, so
//   bubbles are squeezed out and new items are taken while a result waits.
// The table is held in four copies of a small RAM, one per cell corner,
//   all written together; an entry must be written before it is read.
// Reset clears all pipeline valid bits; table contents are not cleared.
// When m_tready is low the output holds, stages fill up behind it and
//   s_tready drops once no stage is free; nothing is lost or repeated.
module bilinear_interp_4x4_grid
    import bilin_pkg::*;
#(
    parameter int GRID_SIDE       = 4,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: entry_index[3:0], entry_value[19:4], x_norm[37:20], y_norm[55:38]
    input  logic [55:0] s_tdata,
    // s_tuser: command[0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: result[15:0]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int F          = COORD_FRAC_BITS;
    localparam int TABLE_SIZE = GRID_SIDE * GRID_SIDE;
    localparam int AW         = $clog2(TABLE_SIZE);
    localparam int IW         = $clog2(GRID_SIDE);
    localparam int GW         = IW + F;
    localparam int MW         = COORD_W + IW + F + 1;
    localparam int PW         = VALUE_W + F + 2;
    localparam int TW         = PW + F + 2;

    localparam logic signed [MW-1:0] SCALE = MW'(GRID_SIDE - 1);
    localparam logic signed [MW-1:0] G_TOP = MW'(((GRID_SIDE - 1) << F) - 1);
    localparam logic        [F:0]    ONE   = (F + 1)'(1) << F;
    localparam logic signed [TW-1:0] RND   = TW'(1) << (2 * F - 1);

    // scale by (side - 1) and clamp to [0, side - 1 - 1 LSB]
    function automatic logic [GW-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
        logic signed [MW-1:0] g;
        logic [GW-1:0] res;
        g = MW'(c) * SCALE;
        if (g < 0)
        begin
            res = '0;
        end
        else if (g > G_TOP)
        begin
            res = G_TOP[GW-1:0];
        end
        else
        begin
            res = g[GW-1:0];
        end
        return res;
    endfunction

    in_item_t in_item;
    assign in_item = in_item_t'(s_tdata);

    // stage enables, chained back from the output
    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    assign en6 = !v6_reg || m_tready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    logic accept;
    logic do_write;
    logic is_interp;
    assign accept    = s_tvalid && s_tready;
    assign is_interp = (s_tuser == CMD_INTERP);
    assign do_write  = accept && (s_tuser == CMD_WRITE)
                       && (int'(in_item.entry_index) < TABLE_SIZE);

    // stage 1: clamped grid coordinates
    logic [GW-1:0] gx_reg, gy_reg;
    logic [GW-1:0] gx_next, gy_next;
    assign gx_next = clamp_coord(in_item.x_norm);
    assign gy_next = clamp_coord(in_item.y_norm);

    // stage 1 -> 2: cell corners and table reads
    logic [IW-1:0] r0, c0, r1, c1;
    logic [AW-1:0] a00, a10, a01, a11;
    assign r0 = gx_reg[GW-1:F];
    assign c0 = gy_reg[GW-1:F];
    assign r1 = r0 + 1'b1;
    assign c1 = c0 + 1'b1;
    assign a00 = AW'(int'(r0) * GRID_SIDE + int'(c0));
    assign a10 = AW'(int'(r1) * GRID_SIDE + int'(c0));
    assign a01 = AW'(int'(r0) * GRID_SIDE + int'(c1));
    assign a11 = AW'(int'(r1) * GRID_SIDE + int'(c1));

    logic [VALUE_W-1:0] e00, e10, e01, e11;
    logic [AW-1:0] wr_addr;
    assign wr_addr = AW'(in_item.entry_index);

    bilin_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SIZE)) u_ram00 (
        .clk(clk), .wr_en(do_write), .wr_addr(wr_addr), .wr_data(in_item.entry_value),
        .rd_en(en2), .rd_addr(a00), .rd_data(e00)
    );
    bilin_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SIZE)) u_ram10 (
        .clk(clk), .wr_en(do_write), .wr_addr(wr_addr), .wr_data(in_item.entry_value),
        .rd_en(en2), .rd_addr(a10), .rd_data(e10)
    );
    bilin_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SIZE)) u_ram01 (
        .clk(clk), .wr_en(do_write), .wr_addr(wr_addr), .wr_data(in_item.entry_value),
        .rd_en(en2), .rd_addr(a01), .rd_data(e01)
    );
    bilin_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SIZE)) u_ram11 (
        .clk(clk), .wr_en(do_write), .wr_addr(wr_addr), .wr_data(in_item.entry_value),
        .rd_en(en2), .rd_addr(a11), .rd_data(e11)
    );

    logic [F-1:0] fx2_reg, fy2_reg;

    // stage 2 -> 3: corner times row weight
    logic [F:0] wx0, wx1;
    assign wx0 = ONE - {1'b0, fx2_reg};
    assign wx1 = {1'b0, fx2_reg};

    logic signed [PW-1:0] p00_next, p10_next, p01_next, p11_next;
    logic signed [PW-1:0] p00_reg, p10_reg, p01_reg, p11_reg;
    logic [F-1:0] fy3_reg;
    assign p00_next = $signed(e00) * $signed({1'b0, wx0});
    assign p10_next = $signed(e10) * $signed({1'b0, wx1});
    assign p01_next = $signed(e01) * $signed({1'b0, wx0});
    assign p11_next = $signed(e11) * $signed({1'b0, wx1});

    // stage 3 -> 4: blend along the row axis
    logic signed [PW-1:0] near_next, far_next, near_reg, far_reg;
    logic [F-1:0] fy4_reg;
    assign near_next = p00_reg + p10_reg;
    assign far_next  = p01_reg + p11_reg;

    // stage 4 -> 5: column weights
    logic [F:0] wy0, wy1;
    assign wy0 = ONE - {1'b0, fy4_reg};
    assign wy1 = {1'b0, fy4_reg};

    logic signed [TW-1:0] q0_next, q1_next, q0_reg, q1_reg;
    assign q0_next = $signed(near_reg) * $signed({1'b0, wy0});
    assign q1_next = $signed(far_reg) * $signed({1'b0, wy1});

    // stage 5 -> 6: sum, round to nearest (ties up), drop fraction
    logic signed [TW-1:0] tot_sum, tot_shift;
    logic [RESULT_W-1:0] result_next, result_reg;
    assign tot_sum     = q0_reg + q1_reg + RND;
    assign tot_shift   = tot_sum >>> (2 * F);
    assign result_next = tot_shift[RESULT_W-1:0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= accept && is_interp;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (en2)
        begin
            fx2_reg <= gx_reg[F-1:0];
            fy2_reg <= gy_reg[F-1:0];
        end
        if (en3)
        begin
            p00_reg <= p00_next;
            p10_reg <= p10_next;
            p01_reg <= p01_next;
            p11_reg <= p11_next;
            fy3_reg <= fy2_reg;
        end
        if (en4)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
            fy4_reg  <= fy3_reg;
        end
        if (en5)
        begin
            q0_reg <= q0_next;
            q1_reg <= q1_next;
        end
        if (en6)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = result_reg;

    // checks
    a_interp_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == CMD_INTERP) |=> v1_reg)
        else $error("interpolate transfer did not enter the pipeline");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == CMD_WRITE) |=> !v1_reg)
        else $error("write transfer entered the result pipeline");

    a_coord_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (MW'(gx_reg) <= G_TOP && MW'(gy_reg) <= G_TOP))
        else $error("clamped coordinate out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !en5) |=> (v5_reg && $stable(q0_reg) && $stable(q1_reg)))
        else $error("stalled stage lost its item");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v6_reg && !m_tready))
        else $error("input refused with room in the pipeline");

endmodule
